// ----- hw/rtl/htw_pkg.sv -----
// Shared types, codes and constants of the hashed timing wheel.
`timescale 1ns / 1ps
package htw_pkg;

   localparam int MAX_TIMERS_DEF = 32;
   localparam int HANDLE_W = 5;
   localparam int SLOT_W = 16;
   localparam int ROT_W = 32;
   localparam logic [SLOT_W-1:0] NUM_SLOTS_RESET = 16'd60000;

   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_ADD = 2'd1;
   localparam logic [1:0] KIND_DEL = 2'd2;

   localparam logic [2:0] ST_ADDED = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_DELETED = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FIRED = 3'd4;
   localparam logic [2:0] ST_NONE = 3'd5;

   localparam logic [1:0] SRC_TIMEOUT = 2'd0;
   localparam logic [1:0] SRC_SUM = 2'd1;
   localparam logic [1:0] SRC_ADV = 2'd2;

   typedef struct packed {
      logic       accept_add;
      logic       add_full;
      logic       del;
      logic       div_go;
      logic [1:0] div_src;
      logic       save_rot;
      logic       add_fix;
      logic       add_div;
      logic       scan_init;
      logic       scan_rd;
      logic       scan_ev;
      logic       tick_end;
      logic       adv_fix;
      logic       adv_div;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic div_done;
      logic sum_small;
      logic adv_small;
      logic scan_done;
   } stat_type;

endpackage

// ----- hw/rtl/htw_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module htw_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [htw_pkg::ROT_W-1:0]  dividend,
   input  logic [htw_pkg::SLOT_W-1:0] divisor,
   output logic                       done,
   output logic [htw_pkg::ROT_W-1:0]  quotient,
   output logic [htw_pkg::SLOT_W-1:0] remainder
);
   import htw_pkg::*;

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [ROT_W-1:0]  quo_ff, quo_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [SLOT_W-1:0] dvs_ff, dvs_in;
   logic [SLOT_W:0]   trial;
   logic [SLOT_W:0]   diff;

   assign trial = {rem_ff, quo_ff[ROT_W-1]};
   assign diff = trial - {1'b0, dvs_ff};

   always_comb begin
      active_in = active_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (go) begin
         active_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (active_ff) begin
         // shift in one dividend bit, subtract if it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[SLOT_W-1:0];
            quo_in = {quo_ff[ROT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SLOT_W-1:0];
            quo_in = {quo_ff[ROT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ROT_W - 1)) begin
            active_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/htw_ctrl.sv -----
// Controller state machine of the timing wheel.
`timescale 1ns / 1ps
module htw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_kind,
   input  htw_pkg::stat_type stat,
   output htw_pkg::cmd_type  cmd,
   output logic              busy
);
   import htw_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ADIV = 4'd1;
   localparam logic [3:0] S_FIX = 4'd2;
   localparam logic [3:0] S_SDIV = 4'd3;
   localparam logic [3:0] S_RD = 4'd4;
   localparam logic [3:0] S_EV = 4'd5;
   localparam logic [3:0] S_TEND = 4'd6;
   localparam logic [3:0] S_TDIV = 4'd7;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_ADD: begin
                     if (stat.full) begin
                        cmd.add_full = 1'b1;
                     end else begin
                        cmd.accept_add = 1'b1;
                        cmd.div_go = 1'b1;
                        cmd.div_src = SRC_TIMEOUT;
                        state_in = S_ADIV;
                     end
                  end
                  KIND_DEL: begin
                     cmd.del = 1'b1;
                  end
                  KIND_TICK: begin
                     cmd.scan_init = 1'b1;
                     state_in = S_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADIV: begin
            if (stat.div_done) begin
               cmd.save_rot = 1'b1;
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (stat.sum_small) begin
               cmd.add_fix = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.div_go = 1'b1;
               cmd.div_src = SRC_SUM;
               state_in = S_SDIV;
            end
         end
         S_SDIV: begin
            if (stat.div_done) begin
               cmd.add_div = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            cmd.scan_ev = 1'b1;
            state_in = stat.scan_done ? S_TEND : S_RD;
         end
         S_TEND: begin
            cmd.tick_end = 1'b1;
            if (stat.adv_small) begin
               cmd.adv_fix = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.div_go = 1'b1;
               cmd.div_src = SRC_ADV;
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            if (stat.div_done) begin
               cmd.adv_div = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- hw/rtl/htw_dp.sv -----
// Datapath of the timing wheel: entry store, divider, scan and result register.
`timescale 1ns / 1ps
module htw_dp #(
   parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  htw_pkg::cmd_type             cmd,
   output htw_pkg::stat_type            stat,
   input  logic [htw_pkg::SLOT_W-1:0]   num_slots,
   input  logic [31:0]                  req_timeout,
   input  logic [htw_pkg::HANDLE_W-1:0] req_handle,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [htw_pkg::HANDLE_W-1:0] rsp_timer_handle,
   output logic                         rsp_last
);
   import htw_pkg::*;

   localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TIMERS - 1);

   logic [SLOT_W-1:0] slot_mem [MAX_TIMERS];
   logic [ROT_W-1:0]  rot_mem [MAX_TIMERS];

   logic [MAX_TIMERS-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]      free_ff, free_in;
   logic [ROT_W-1:0]      rot_ff, rot_in;
   logic [SLOT_W:0]       sum_ff, sum_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pidx_ff, pidx_in;
   logic [SLOT_W-1:0]     slot_q_ff;
   logic [ROT_W-1:0]      rot_q_ff;
   logic                  rv_ff, rv_in;
   logic [2:0]            rs_ff, rs_in;
   logic [HANDLE_W-1:0]   rh_ff, rh_in;
   logic                  rl_ff, rl_in;

   logic [IDX_W-1:0]  free_idx;
   logic              div_done;
   logic [ROT_W-1:0]  div_quo;
   logic [SLOT_W-1:0] div_rem;
   logic [ROT_W-1:0]  div_dividend;
   logic [SLOT_W:0]   sum_sub, adv, adv_sub;
   logic [SLOT_W-1:0] sum_red, adv_red;
   logic              hit, fire;
   logic              del_found;
   logic              slot_we, rot_we;
   logic [IDX_W-1:0]  wr_addr;
   logic [SLOT_W-1:0] slot_wd;
   logic [ROT_W-1:0]  rot_wd;

   // lowest free entry
   always_comb begin
      free_idx = '0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign sum_sub = sum_ff - {1'b0, num_slots};
   assign sum_red = (sum_ff < {1'b0, num_slots}) ? sum_ff[SLOT_W-1:0] : sum_sub[SLOT_W-1:0];
   assign adv = {1'b0, cur_ff} + 17'd1;
   assign adv_sub = adv - {1'b0, num_slots};
   assign adv_red = (adv < {1'b0, num_slots}) ? adv[SLOT_W-1:0] : adv_sub[SLOT_W-1:0];

   always_comb begin
      unique case (cmd.div_src)
         SRC_TIMEOUT: div_dividend = req_timeout;
         SRC_SUM:     div_dividend = {{(ROT_W-SLOT_W-1){1'b0}}, sum_ff};
         SRC_ADV:     div_dividend = {{(ROT_W-SLOT_W-1){1'b0}}, adv};
         default:     div_dividend = req_timeout;
      endcase
   end

   htw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.div_go),
      .dividend  (div_dividend),
      .divisor   (num_slots),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign hit = valid_ff[idx_ff] && (slot_q_ff == cur_ff);
   assign fire = hit && (rot_q_ff == '0);
   assign del_found = (32'(req_handle) < MAX_TIMERS) && valid_ff[req_handle[IDX_W-1:0]];

   assign slot_we = cmd.add_fix || cmd.add_div;
   assign rot_we = slot_we || (cmd.scan_ev && hit && !fire);
   assign wr_addr = cmd.scan_ev ? idx_ff : free_ff;
   assign slot_wd = cmd.add_fix ? sum_red : div_rem;
   assign rot_wd = cmd.scan_ev ? (rot_q_ff - 32'd1) : rot_ff;

   always_comb begin
      valid_in = valid_ff;
      cur_in = cur_ff;
      free_in = free_ff;
      rot_in = rot_ff;
      sum_in = sum_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      pidx_in = pidx_ff;
      rv_in = 1'b0;
      rs_in = rs_ff;
      rh_in = rh_ff;
      rl_in = rl_ff;
      if (cmd.accept_add) begin
         free_in = free_idx;
      end
      if (cmd.add_full) begin
         rv_in = 1'b1;
         rs_in = ST_FULL;
         rh_in = '0;
         rl_in = 1'b1;
      end
      if (cmd.del) begin
         rv_in = 1'b1;
         rs_in = del_found ? ST_DELETED : ST_NOTFOUND;
         rh_in = req_handle;
         rl_in = 1'b1;
         if (del_found) begin
            valid_in[req_handle[IDX_W-1:0]] = 1'b0;
         end
      end
      if (cmd.save_rot) begin
         rot_in = div_quo;
         sum_in = {1'b0, cur_ff} + {1'b0, div_rem};
      end
      if (slot_we) begin
         valid_in[free_ff] = 1'b1;
         rv_in = 1'b1;
         rs_in = ST_ADDED;
         rh_in = HANDLE_W'(free_ff);
         rl_in = 1'b1;
      end
      if (cmd.scan_init) begin
         idx_in = '0;
         pend_in = 1'b0;
      end
      if (cmd.scan_ev) begin
         idx_in = idx_ff + 1'b1;
         if (fire) begin
            valid_in[idx_ff] = 1'b0;
            pend_in = 1'b1;
            pidx_in = idx_ff;
            if (pend_ff) begin
               rv_in = 1'b1;
               rs_in = ST_FIRED;
               rh_in = HANDLE_W'(pidx_ff);
               rl_in = 1'b0;
            end
         end
      end
      if (cmd.tick_end) begin
         rv_in = 1'b1;
         rs_in = pend_ff ? ST_FIRED : ST_NONE;
         rh_in = pend_ff ? HANDLE_W'(pidx_ff) : '0;
         rl_in = 1'b1;
      end
      if (cmd.adv_fix) begin
         cur_in = adv_red;
      end
      if (cmd.adv_div) begin
         cur_in = div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[wr_addr] <= slot_wd;
      end
      if (rot_we) begin
         rot_mem[wr_addr] <= rot_wd;
      end
      if (cmd.scan_rd) begin
         slot_q_ff <= slot_mem[idx_ff];
         rot_q_ff <= rot_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cur_ff <= '0;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         cur_ff <= cur_in;
         rv_ff <= rv_in;
         pend_ff <= pend_in;
         idx_ff <= idx_in;
      end
      free_ff <= free_in;
      rot_ff <= rot_in;
      sum_ff <= sum_in;
      pidx_ff <= pidx_in;
      rs_ff <= rs_in;
      rh_ff <= rh_in;
      rl_ff <= rl_in;
   end

   assign stat.full = &valid_ff;
   assign stat.div_done = div_done;
   assign stat.sum_small = (sum_ff < {1'b0, num_slots}) || (sum_sub < {1'b0, num_slots});
   assign stat.adv_small = (adv < {1'b0, num_slots}) || (adv_sub < {1'b0, num_slots});
   assign stat.scan_done = (idx_ff == IDX_LAST);

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_timer_handle = rh_ff;
   assign rsp_last = rl_ff;

endmodule

// ----- hw/rtl/hashed_timing_wheel.sv -----
// Top level of the hashed timing wheel: register port, controller and datapath.
`timescale 1ns / 1ps
// Hashed timing wheel over MAX_TIMERS timer entries. Raise start with a word on
// req_* while busy is low; the word is taken at that edge. Each result word shows
// on rsp_* for one cycle with rsp_valid high and cannot be held off; rsp_last
// marks the final word of a command. A delete answers in the cycle after it is
// taken. An add runs the 32-step serial divider that splits the timeout into
// slot and rotations, and a second division when the current slot plus the
// remainder reaches twice the slot count. A tick reads and then evaluates each
// entry in turn from the single-port entry memory, and runs the divider when the
// wheel position must be reduced by it. Write num_slots at byte address 0
// only while idle; a write of zero is stored as one.
module hashed_timing_wheel #(
   parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [31:0]                  req_timeout,
   input  logic [htw_pkg::HANDLE_W-1:0] req_handle,
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [htw_pkg::HANDLE_W-1:0] rsp_timer_handle,
   output logic                         rsp_last,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import htw_pkg::*;

   logic [SLOT_W-1:0] slots_ff, slots_in;
   cmd_type           cmd;
   stat_type          stat;

   // Register write: only num_slots at index zero, zero coerced to one.
   always_comb begin
      slots_in = slots_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         slots_in = (pwdata[SLOT_W-1:0] == '0) ? 16'd1 : pwdata[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= NUM_SLOTS_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {16'd0, slots_ff};

   // Sequence each command.
   htw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Hold entries, wheel position and the result register.
   htw_dp #(
      .MAX_TIMERS (MAX_TIMERS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .num_slots        (slots_ff),
      .req_timeout      (req_timeout),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_timer_handle (rsp_timer_handle),
      .rsp_last         (rsp_last)
   );

   // A result word only follows an accepted command or work in progress.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start))
      else $error("result word without a command");

   // Only fired words may come without the last mark.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FIRED) |-> rsp_last)
      else $error("single result word missing last mark");

   // A tick always occupies the block for its scan.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_kind == KIND_TICK) |=> busy)
      else $error("tick did not start a scan");

endmodule
